// File: hw/rtl/gbi_pkg.sv
// ----------------------------------------------------------------------------
// gbi_pkg: shared constants and types of the gain grid interpolator
// Grid geometry, field widths, bank layout and the inter-stage structs.
// ----------------------------------------------------------------------------
package gbi_pkg;

    // grid geometry and fixed-point format
    localparam int GRID_W     = 52;
    localparam int GRID_H     = 39;
    localparam int FRAC_BITS  = 8;
    localparam int GRID_SIZE  = GRID_W * GRID_H;

    // item field widths
    localparam int IDX_W      = 11;
    localparam int VAL_W      = 16;
    localparam int POS_W      = 14;
    localparam int OUT_W      = 24;
    localparam int INT_W      = POS_W - FRAC_BITS;

    localparam int COL_W      = $clog2(GRID_W);
    localparam int ROW_W      = $clog2(GRID_H);

    // four banks by (row parity, column parity)
    localparam int NUM_BANKS  = 4;
    localparam int BANK_COLS  = (GRID_W + 1) / 2;
    localparam int BANK_ROWS  = (GRID_H + 1) / 2;
    localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
    localparam int BADDR_W    = $clog2(BANK_DEPTH);

    // weights are Q0.(2*FRAC_BITS) and reach exactly 2^(2*FRAC_BITS)
    localparam int ONE        = 2 ** FRAC_BITS;
    localparam int WGT_W      = 2 * FRAC_BITS + 1;
    localparam int PROD_W     = VAL_W + 2 * FRAC_BITS;

    // row = (index * DIV_MULT) >> DIV_SHIFT, exact for every 11-bit index
    localparam int DIV_SHIFT  = 18;
    localparam int DIV_MULT   = (2 ** DIV_SHIFT + GRID_W - 1) / GRID_W;
    localparam int DIV_MULT_W = $clog2(DIV_MULT + 1);
    localparam int DPROD_W    = IDX_W + DIV_MULT_W;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_SAMPLE = 1'b1
    } gbi_kind_t;

    typedef logic [1:0] gbi_bank_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } gbi_cell_t;

    // sample info leaving stage 2
    typedef struct packed {
        logic                             smp;
        logic [NUM_BANKS-1:0][WGT_W-1:0]  wgt;
        logic [NUM_BANKS-1:0][1:0]        nsel;
    } gbi_s2_t;

    // grid write leaving stage 2
    typedef struct packed {
        logic             req;
        gbi_bank_t        bank;
        logic [VAL_W-1:0] data;
    } gbi_wr_t;

    typedef struct packed {
        logic en1;
        logic en2;
    } gbi_front_ctl_t;

    typedef struct packed {
        logic busy1;
        logic busy2;
    } gbi_front_sts_t;

    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
    } gbi_back_ctl_t;

    typedef struct packed {
        logic busy3;
        logic busy4;
        logic busy5;
    } gbi_back_sts_t;

endpackage

// File: hw/rtl/gbi_req_if.sv
// ----------------------------------------------------------------------------
// gbi_req_if: input item channel
// Valid/ready channel carrying grid writes and sample points.
// ----------------------------------------------------------------------------
interface gbi_req_if import gbi_pkg::*; ();

    logic             valid;
    logic             ready;
    gbi_kind_t        kind;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] entry_value;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;

    modport source (
        output valid,
        output kind,
        output entry_index,
        output entry_value,
        output x_pos,
        output y_pos,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  entry_index,
        input  entry_value,
        input  x_pos,
        input  y_pos,
        output ready
    );

endinterface

// File: hw/rtl/gbi_rsp_if.sv
// ----------------------------------------------------------------------------
// gbi_rsp_if: result item channel
// Valid/ready channel carrying interpolated gains.
// ----------------------------------------------------------------------------
interface gbi_rsp_if import gbi_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] gain_out;

    modport source (
        output valid,
        output gain_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  gain_out,
        output ready
    );

endinterface

// File: hw/rtl/gbi_front.sv
// ----------------------------------------------------------------------------
// gbi_front: decode stages 1 and 2
// Splits write indexes into row/column and sample points into neighbor
// cells, weights and per-bank cell addresses.
// ----------------------------------------------------------------------------
module gbi_front import gbi_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbi_front_ctl_t                ctl,
    output gbi_front_sts_t                sts,
    input  logic                          in_valid,
    input  gbi_kind_t                     kind,
    input  logic [IDX_W-1:0]              entry_index,
    input  logic [VAL_W-1:0]              entry_value,
    input  logic [POS_W-1:0]              x_pos,
    input  logic [POS_W-1:0]              y_pos,
    output gbi_s2_t                       s2_info,
    output gbi_cell_t [NUM_BANKS-1:0]     s2_cell,
    output gbi_wr_t                       s2_wr
);

    // stage 1 registers
    logic                 busy1_reg;
    logic                 smp1_reg;
    logic [IDX_W-1:0]     idx1_reg;
    logic [VAL_W-1:0]     val1_reg;
    logic [ROW_W-1:0]     wrow1_reg;
    logic                 wok1_reg;
    logic [COL_W-1:0]     c0_reg, c1_reg;
    logic [ROW_W-1:0]     r0_reg, r1_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;

    // stage 2 registers
    logic                            busy2_reg;
    gbi_s2_t                         info2_reg;
    gbi_cell_t [NUM_BANKS-1:0]       cell2_reg;
    gbi_wr_t                         wr2_reg;

    // stage 1 next values
    logic [INT_W-1:0]     xi, yi;
    logic [FRAC_BITS-1:0] fx_next, fy_next;
    logic [INT_W:0]       xi_up, yi_up;
    logic [ROW_W-1:0]     yc0, yc1;
    logic [COL_W-1:0]     c0_next, c1_next;
    logic [ROW_W-1:0]     r0_next, r1_next;
    logic [DPROD_W-1:0]   dprod;
    logic [ROW_W-1:0]     wrow_next;

    // stage 2 next values
    logic [WGT_W-1:0]                wfx, wfy, wifx, wify;
    logic [COL_W-1:0]                wcol;
    gbi_s2_t                         info2_next;
    gbi_cell_t [NUM_BANKS-1:0]       cell2_next;
    gbi_wr_t                         wr2_next;

    always_comb
    begin
        xi      = x_pos[POS_W-1:FRAC_BITS];
        yi      = y_pos[POS_W-1:FRAC_BITS];
        fx_next = x_pos[FRAC_BITS-1:0];
        fy_next = y_pos[FRAC_BITS-1:0];
        xi_up   = {1'b0, xi} + (INT_W+1)'(fx_next != '0);
        yi_up   = {1'b0, yi} + (INT_W+1)'(fy_next != '0);

        c0_next = (xi > INT_W'(GRID_W - 1)) ? COL_W'(GRID_W - 1) : COL_W'(xi);
        c1_next = (xi_up > (INT_W+1)'(GRID_W - 1)) ? COL_W'(GRID_W - 1) : COL_W'(xi_up);
        yc0     = (yi > INT_W'(GRID_H - 1)) ? ROW_W'(GRID_H - 1) : ROW_W'(yi);
        yc1     = (yi_up > (INT_W+1)'(GRID_H - 1)) ? ROW_W'(GRID_H - 1) : ROW_W'(yi_up);
        // rows run bottom-up in the grid
        r0_next = ROW_W'(GRID_H - 1) - yc0;
        r1_next = ROW_W'(GRID_H - 1) - yc1;

        // index / GRID_W by reciprocal multiply
        dprod     = DPROD_W'(entry_index) * DPROD_W'(DIV_MULT);
        wrow_next = ROW_W'(dprod >> DIV_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy1_reg <= 1'b0;
            busy2_reg <= 1'b0;
        end
        else
        begin
            if (ctl.en1)
            begin
                busy1_reg <= in_valid;
            end
            if (ctl.en2)
            begin
                busy2_reg <= busy1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            smp1_reg  <= (kind == KIND_SAMPLE);
            idx1_reg  <= entry_index;
            val1_reg  <= entry_value;
            wrow1_reg <= wrow_next;
            wok1_reg  <= (entry_index < IDX_W'(GRID_SIZE));
            c0_reg    <= c0_next;
            c1_reg    <= c1_next;
            r0_reg    <= r0_next;
            r1_reg    <= r1_next;
            fx_reg    <= fx_next;
            fy_reg    <= fy_next;
        end
    end

    always_comb
    begin
        wfx  = WGT_W'(fx_reg);
        wfy  = WGT_W'(fy_reg);
        wifx = WGT_W'(ONE) - wfx;
        wify = WGT_W'(ONE) - wfy;
        wcol = COL_W'(idx1_reg - IDX_W'(wrow1_reg * GRID_W));

        info2_next.smp     = smp1_reg;
        info2_next.wgt[0]  = wifx * wify;
        info2_next.wgt[1]  = wfx * wify;
        info2_next.wgt[2]  = wifx * wfy;
        info2_next.wgt[3]  = wfx * wfy;
        info2_next.nsel[0] = {r0_reg[0], c0_reg[0]};
        info2_next.nsel[1] = {r0_reg[0], c1_reg[0]};
        info2_next.nsel[2] = {r1_reg[0], c0_reg[0]};
        info2_next.nsel[3] = {r1_reg[0], c1_reg[0]};

        // each bank gets the neighbor of matching row and column parity
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (smp1_reg)
            begin
                cell2_next[b].row = (r0_reg[0] == b[1]) ? r0_reg : r1_reg;
                cell2_next[b].col = (c0_reg[0] == b[0]) ? c0_reg : c1_reg;
            end
            else
            begin
                cell2_next[b].row = wrow1_reg;
                cell2_next[b].col = wcol;
            end
        end

        wr2_next.req  = !smp1_reg && wok1_reg;
        wr2_next.bank = {wrow1_reg[0], wcol[0]};
        wr2_next.data = val1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en2)
        begin
            info2_reg <= info2_next;
            cell2_reg <= cell2_next;
            wr2_reg   <= wr2_next;
        end
    end

    assign sts.busy1 = busy1_reg;
    assign sts.busy2 = busy2_reg;
    assign s2_info   = info2_reg;
    assign s2_cell   = cell2_reg;
    assign s2_wr     = wr2_reg;

    // neighbors are at most one line apart; mirrored rows run downward
    a_nbr_lines: assert property (@(posedge clk) disable iff (!rst_n)
        busy1_reg && smp1_reg |->
            (c1_reg == c0_reg || c1_reg == c0_reg + COL_W'(1)) &&
            (r0_reg == r1_reg || r0_reg == r1_reg + ROW_W'(1)))
        else $error("gbi_front: neighbor lines out of step");

endmodule

// File: hw/rtl/gbi_bank.sv
// ----------------------------------------------------------------------------
// gbi_bank: one parity bank of the gain grid
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module gbi_bank import gbi_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  gbi_cell_t        loc,
    input  logic [VAL_W-1:0] wdata,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0]   grid_mem [BANK_DEPTH];
    logic [VAL_W-1:0]   rdata_reg;
    logic [BADDR_W-1:0] baddr;

    // entry (row, col) lives at (row/2, col/2) of its bank
    assign baddr = BADDR_W'(loc.row[ROW_W-1:1]) * BADDR_W'(BANK_COLS)
                 + BADDR_W'(loc.col[COL_W-1:1]);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            grid_mem[baddr] <= wdata;
        end
        if (en)
        begin
            rdata_reg <= grid_mem[baddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/gbi_blend.sv
// ----------------------------------------------------------------------------
// gbi_blend: blend stages 3 to 5
// Routes bank data to neighbors, multiplies by weights, sums and truncates.
// ----------------------------------------------------------------------------
module gbi_blend import gbi_pkg::*; (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gbi_back_ctl_t                   ctl,
    output gbi_back_sts_t                   sts,
    input  logic                            busy2,
    input  gbi_s2_t                         s2_info,
    input  logic [NUM_BANKS-1:0][VAL_W-1:0] rdata,
    output logic [OUT_W-1:0]                gain
);

    logic                             busy3_reg, busy4_reg, busy5_reg;
    gbi_s2_t                          info3_reg;
    logic [NUM_BANKS-1:0][PROD_W-1:0] prod4_reg;
    logic [OUT_W-1:0]                 gain5_reg;

    logic [NUM_BANKS-1:0][PROD_W-1:0] prod4_next;
    logic [PROD_W+1:0]                acc;
    logic [WGT_W+1:0]                 wgt_sum;

    always_comb
    begin
        for (int k = 0; k < NUM_BANKS; k++)
        begin
            prod4_next[k] = rdata[info3_reg.nsel[k]] * info3_reg.wgt[k];
        end
        acc = {2'b00, prod4_reg[0]} + {2'b00, prod4_reg[1]}
            + {2'b00, prod4_reg[2]} + {2'b00, prod4_reg[3]};
        wgt_sum = {2'b00, info3_reg.wgt[0]} + {2'b00, info3_reg.wgt[1]}
                + {2'b00, info3_reg.wgt[2]} + {2'b00, info3_reg.wgt[3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy3_reg <= 1'b0;
            busy4_reg <= 1'b0;
            busy5_reg <= 1'b0;
        end
        else
        begin
            if (ctl.en3)
            begin
                busy3_reg <= busy2;
            end
            // write items end here
            if (ctl.en4)
            begin
                busy4_reg <= busy3_reg && info3_reg.smp;
            end
            if (ctl.en5)
            begin
                busy5_reg <= busy4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en3)
        begin
            info3_reg <= s2_info;
        end
        if (ctl.en4)
        begin
            prod4_reg <= prod4_next;
        end
        if (ctl.en5)
        begin
            gain5_reg <= acc[FRAC_BITS +: OUT_W];
        end
    end

    assign sts.busy3 = busy3_reg;
    assign sts.busy4 = busy4_reg;
    assign sts.busy5 = busy5_reg;
    assign gain      = gain5_reg;

    // bilinear weights always partition unity
    a_wgt_sum: assert property (@(posedge clk) disable iff (!rst_n)
        busy3_reg && info3_reg.smp |-> wgt_sum == (WGT_W+2)'(ONE * ONE))
        else $error("gbi_blend: weights do not sum to one");

endmodule

// File: hw/rtl/gain_grid_bilinear_interp_unit.sv
// ----------------------------------------------------------------------------
// gain_grid_bilinear_interp_unit: lens-shading gain grid with bilinear lookup
// Stores a 52x39 grid of 16-bit gains and samples it at Q6.8 points.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink)   one item per handshake. kind = write stores entry_value at
//                 entry_index (row * 52 + col; indexes past the grid are
//                 dropped). kind = sample blends the four grid gains around
//                 (x_pos, y_pos), rows mirrored, and returns one item.
//   rsp  (source) gain_out, Q16.8, truncated. Write items give no result.
//   Pipeline: a sample reaches rsp through five registered stages: decode,
//   weights/addresses, bank read, products, sum.
//   Throughput: one item per cycle while rsp is not held. The four neighbors
//   come from four parity banks (row parity x column parity), one read each
//   per cycle; a write and a read meet the banks in the same stage, so item
//   order holds.
//   Reset clears only the stage valid bits; grid contents are undefined until
//   written, and the block is ready in the first cycle after reset.
//   Stall: when rsp is held, each stage holds if the next one is full and
//   otherwise fills its bubble; req.ready drops only when every stage is full.
// ----------------------------------------------------------------------------
module gain_grid_bilinear_interp_unit import gbi_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    gbi_req_if.sink      req,
    gbi_rsp_if.source    rsp
);

    gbi_front_ctl_t                  front_ctl;
    gbi_front_sts_t                  front_sts;
    gbi_back_ctl_t                   back_ctl;
    gbi_back_sts_t                   back_sts;

    gbi_s2_t                         s2_info;
    gbi_cell_t [NUM_BANKS-1:0]       s2_cell;
    gbi_wr_t                         s2_wr;

    logic [NUM_BANKS-1:0]            bank_we;
    logic [NUM_BANKS-1:0][VAL_W-1:0] bank_rdata;

    // per-stage advance: a stage loads when it is empty or its successor moves
    always_comb
    begin
        back_ctl.en5  = !back_sts.busy5 || rsp.ready;
        back_ctl.en4  = !back_sts.busy4 || back_ctl.en5;
        back_ctl.en3  = !back_sts.busy3 || back_ctl.en4;
        front_ctl.en2 = !front_sts.busy2 || back_ctl.en3;
        front_ctl.en1 = !front_sts.busy1 || front_ctl.en2;
    end

    assign req.ready = front_ctl.en1;

    gbi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (front_ctl),
        .sts         (front_sts),
        .in_valid    (req.valid),
        .kind        (req.kind),
        .entry_index (req.entry_index),
        .entry_value (req.entry_value),
        .x_pos       (req.x_pos),
        .y_pos       (req.y_pos),
        .s2_info     (s2_info),
        .s2_cell     (s2_cell),
        .s2_wr       (s2_wr)
    );

    // grid write lands in the bank matching its row/column parity
    always_comb
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            bank_we[b] = front_sts.busy2 && back_ctl.en3 && s2_wr.req
                      && (s2_wr.bank == gbi_bank_t'(b));
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++)
    begin : g_bank
        gbi_bank u_bank (
            .clk   (clk),
            .en    (back_ctl.en3),
            .we    (bank_we[g]),
            .loc   (s2_cell[g]),
            .wdata (s2_wr.data),
            .rdata (bank_rdata[g])
        );
    end

    gbi_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (back_ctl),
        .sts     (back_sts),
        .busy2   (front_sts.busy2),
        .s2_info (s2_info),
        .rdata   (bank_rdata),
        .gain    (rsp.gain_out)
    );

    assign rsp.valid = back_sts.busy5;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_one_bank_we: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bank_we))
        else $error("gbi: grid write hits more than one bank");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        front_sts.busy1 && front_sts.busy2 && back_sts.busy3 &&
        back_sts.busy4 && back_sts.busy5 && !rsp.ready |-> !req.ready)
        else $error("gbi: item accepted into a full stalled pipeline");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> front_sts.busy1)
        else $error("gbi: accepted item not held in stage 1");

endmodule

// File: bench/gain_grid_bilinear_interp_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gain_grid_bilinear_interp_unit_tb: self-checking bench for the gain grid
// Drives grid writes and sample points over the req channel. A local copy of
// the grid predicts each interpolated gain, and every rsp item is compared
// in order. Traffic runs under several sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module gain_grid_bilinear_interp_unit_tb import gbi_pkg::*; ();

    localparam int CLK_PERIOD   = 2;
    localparam int RESET_CYCLES = 10;
    localparam int PHASE_ITEMS  = 305;     // four phases, about 1250 items in all
    localparam int SETTLE_EDGES = 16;      // pipeline is five stages deep
    localparam int TIMEOUT_NS   = 400_000;

    // one row of the directed table
    typedef struct packed {
        gbi_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             typed;       // gain below is known at a glance
        logic [OUT_W-1:0] gain;
    } stim_row_t;

    localparam int DIR_ROWS = 21;

    // Corner of the grid (col 0, mirrored row 38) is entry 1976; the far
    // corner (col 51, mirrored row 0) is entry 51. Entry 2027 is the last
    // in range, 2028 and 2047 must be dropped.
    localparam stim_row_t DIR_TBL [DIR_ROWS] = '{
        '{KIND_WRITE,  11'd1976, 16'h0001, 14'd0,     14'd0,     1'b0, 24'h0},
        '{KIND_SAMPLE, 11'd0,    16'h0,    14'd0,     14'd0,     1'b1, 24'h000100},
        '{KIND_WRITE,  11'd51,   16'hFFFF, 14'd0,     14'd0,     1'b0, 24'h0},
        '{KIND_SAMPLE, 11'd0,    16'h0,    14'd16383, 14'd16383, 1'b1, 24'hFFFF00},
        '{KIND_SAMPLE, 11'd0,    16'h0,    14'd13056, 14'd9728,  1'b1, 24'hFFFF00},
        '{KIND_WRITE,  11'd2027, 16'h8000, 14'd0,     14'd0,     1'b0, 24'h0},
        '{KIND_WRITE,  11'd2047, 16'h1234, 14'd16383, 14'd16383, 1'b0, 24'h0},
        '{KIND_WRITE,  11'd2028, 16'hABCD, 14'd0,     14'd0,     1'b0, 24'h0},
        '{KIND_WRITE,  11'd1977, 16'h0100, 14'd0,     14'd0,     1'b0, 24'h0},
        '{KIND_WRITE,  11'd1924, 16'h00FF, 14'd0,     14'd0,     1'b0, 24'h0},
        '{KIND_WRITE,  11'd1925, 16'hFFFF, 14'd0,     14'd0,     1'b0, 24'h0},
        '{KIND_SAMPLE, 11'd0,    16'h0,    14'h080,   14'h080,   1'b0, 24'h0},
        '{KIND_SAMPLE, 11'd2047, 16'hFFFF, 14'h0FF,   14'h0FF,   1'b0, 24'h0},
        '{KIND_SAMPLE, 11'd0,    16'h0,    14'h001,   14'h000,   1'b0, 24'h0},
        '{KIND_SAMPLE, 11'd0,    16'h0,    14'd13184, 14'd0,     1'b1, 24'h800000},
        '{KIND_SAMPLE, 11'd0,    16'h0,    14'd16383, 14'd0,     1'b1, 24'h800000},
        '{KIND_WRITE,  11'd0,    16'h7FFF, 14'd0,     14'd0,     1'b0, 24'h0},
        '{KIND_SAMPLE, 11'd0,    16'h0,    14'd0,     14'd16383, 1'b1, 24'h7FFF00},
        '{KIND_WRITE,  11'd0,    16'h0000, 14'd0,     14'd0,     1'b0, 24'h0},
        '{KIND_SAMPLE, 11'd0,    16'h0,    14'd0,     14'd9728,  1'b1, 24'h000000},
        '{KIND_SAMPLE, 11'd0,    16'h0,    14'h100,   14'd0,     1'b1, 24'h010000}
    };

    // idle mixes per random phase, in percent of cycles
    localparam int SRC_IDLE_TBL  [4] = '{0, 69, 0, 26};
    localparam int RSP_STALL_TBL [4] = '{0, 0, 69, 26};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    gbi_req_if req_ch ();
    gbi_rsp_if rsp_ch ();

    gain_grid_bilinear_interp_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow of the gain grid plus a map of entries written since reset
    logic [VAL_W-1:0] gain_mem [GRID_SIZE];
    bit               written  [GRID_SIZE];

    logic [OUT_W-1:0] gain_q [$];          // interpolated gains still owed by the DUT
    logic [OUT_W-1:0] want_gain;

    int src_idle_pct  = 0;
    int rsp_stall_pct = 0;
    int err_count     = 0;
    int items_sent    = 0;                 // accepted items that do something

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got,
                                   logic [OUT_W-1:0] want);
        $display("[%0t] mismatch: %s got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    // Grid entry of one of the four neighbors of (x, y).
    // k[0] picks the right column, k[1] the upper row (before mirroring).
    // With a zero fraction the "next" line collapses onto the floor line.
    function automatic int unsigned corner_cell(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                                int k);
        int unsigned col;
        int unsigned row;
        col = x >> FRAC_BITS;
        row = y >> FRAC_BITS;
        if (k[0] && x[FRAC_BITS-1:0] != 0)
            col++;
        if (k[1] && y[FRAC_BITS-1:0] != 0)
            row++;
        if (col > GRID_W - 1)
            col = GRID_W - 1;
        if (row > GRID_H - 1)
            row = GRID_H - 1;
        return (GRID_H - 1 - row) * GRID_W + col;
    endfunction

    // Bilinear blend of the shadow grid; weights are Q0.16, sum is 2^16.
    // Result keeps 8 fraction bits, truncated.
    function automatic logic [OUT_W-1:0] interp_gain(logic [POS_W-1:0] x,
                                                     logic [POS_W-1:0] y);
        longint unsigned fx;
        longint unsigned fy;
        longint unsigned acc;
        longint unsigned shifted;
        fx  = x[FRAC_BITS-1:0];
        fy  = y[FRAC_BITS-1:0];
        acc = longint'(gain_mem[corner_cell(x, y, 0)]) * (ONE - fx) * (ONE - fy)
            + longint'(gain_mem[corner_cell(x, y, 1)]) * fx * (ONE - fy)
            + longint'(gain_mem[corner_cell(x, y, 2)]) * (ONE - fx) * fy
            + longint'(gain_mem[corner_cell(x, y, 3)]) * fx * fy;
        shifted = acc >> FRAC_BITS;
        return shifted[OUT_W-1:0];
    endfunction

    // gains lean toward the rails now and then
    function automatic logic [VAL_W-1:0] pick_gain();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return VAL_W'($urandom_range(65535));
    endfunction

    // Sample coordinate: mostly inside the grid with a biased fraction
    // (exact grid lines and the top fraction are worth hitting), the rest
    // anywhere in the 14-bit range, which exercises clamping.
    function automatic logic [POS_W-1:0] pick_pos(int last_line);
        int unsigned frac;
        int r;
        if ($urandom_range(9) >= 7)
            return POS_W'($urandom_range(16383));
        r = $urandom_range(19);
        if (r < 5)
            frac = 0;
        else if (r < 7)
            frac = ONE - 1;
        else
            frac = $urandom_range(ONE - 1);
        return POS_W'(($urandom_range(last_line) << FRAC_BITS) | frac);
    endfunction

    // Present one item, with random sender gaps in front of it, and wait for
    // the handshake. Ready is sampled at the edge, so it is the value the DUT
    // saw. On acceptance the shadow grid or the result queue is updated.
    task automatic send_item(gbi_kind_t k, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                             logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic typed, logic [OUT_W-1:0] typed_gain);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= k;
        req_ch.entry_index <= idx;
        req_ch.entry_value <= val;
        req_ch.x_pos       <= x;
        req_ch.y_pos       <= y;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        if (k == KIND_WRITE)
        begin
            // indexes past the grid are dropped by the block
            if (idx < GRID_SIZE)
            begin
                gain_mem[idx] = val;
                written[idx]  = 1'b1;
                items_sent++;
            end
        end
        else
        begin
            gain_q.push_back(typed ? typed_gain : interp_gain(x, y));
            items_sent++;
        end
    endtask

    // stop sending until every owed gain has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (gain_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int               phase_end;
        int unsigned      nbr_idx;
        logic [POS_W-1:0] sx;
        logic [POS_W-1:0] sy;

        req_ch.valid       <= 1'b0;
        req_ch.kind        <= KIND_WRITE;
        req_ch.entry_index <= '0;
        req_ch.entry_value <= '0;
        req_ch.x_pos       <= '0;
        req_ch.y_pos       <= '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: corners, clamping, dropped writes, overwrite
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIR_TBL[i].kind, DIR_TBL[i].idx, DIR_TBL[i].val, DIR_TBL[i].x,
                      DIR_TBL[i].y, DIR_TBL[i].typed, DIR_TBL[i].gain);
        wait_drained();

        // Random part. Samples dominate; before each sample, any neighbor
        // that was never written gets a write of its own so no undefined
        // entry is ever read. A slice of plain writes lands anywhere in the
        // 11-bit index space, out-of-range ones included.
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct  = SRC_IDLE_TBL[ph];
            rsp_stall_pct = RSP_STALL_TBL[ph];
            phase_end     = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(99) < 20)
                begin
                    send_item(KIND_WRITE, IDX_W'($urandom_range(2047)), pick_gain(),
                              POS_W'($urandom_range(16383)), POS_W'($urandom_range(16383)),
                              1'b0, '0);
                end
                else
                begin
                    sx = pick_pos(GRID_W - 1);
                    sy = pick_pos(GRID_H - 1);
                    for (int k = 0; k < 4; k++)
                    begin
                        nbr_idx = corner_cell(sx, sy, k);
                        if (!written[nbr_idx])
                            send_item(KIND_WRITE, IDX_W'(nbr_idx), pick_gain(),
                                      POS_W'($urandom_range(16383)),
                                      POS_W'($urandom_range(16383)), 1'b0, '0);
                    end
                    send_item(KIND_SAMPLE, IDX_W'($urandom_range(2047)),
                              VAL_W'($urandom_range(65535)), sx, sy, 1'b0, '0);
                end
            end
            // sender holds off between phases until the pipe is empty
            wait_drained();
        end

        repeat (SETTLE_EDGES) @(posedge clk);
        if (err_count == 0 && gain_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure and in-order compare
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (gain_q.size() == 0)
            begin
                report_mismatch("gain item with none outstanding", rsp_ch.gain_out, '0);
            end
            else
            begin
                want_gain = gain_q.pop_front();
                if (rsp_ch.gain_out !== want_gain)
                    report_mismatch("gain_out", rsp_ch.gain_out, want_gain);
            end
        end
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= rsp_stall_pct);
    end

    // hard stop if the handshakes hang
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
